// ===== sv/pnt_pkg.sv =====
package pnt_pkg;

   // Store geometry and counter width
   localparam int ASSEMBLIES          = 24;
   localparam int STRIPS_PER_ASSEMBLY = 1280;
   localparam int COUNT_BITS          = 24;
   localparam int STORE_DEPTH         = ASSEMBLIES * STRIPS_PER_ASSEMBLY;
   localparam int ADDR_BITS           = $clog2(STORE_DEPTH);
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

   // Fixed field widths
   localparam int Q_BITS   = 20;
   localparam int SSD_BITS = 56;
   localparam int DIV_BITS = 64;
   localparam int STEP_BITS = 7;

   // Divider step counts: rounded mean, squared deviation, variance
   localparam int MEAN_DIV_STEPS = (COUNT_BITS > 21 ? COUNT_BITS : 21) + 1;
   localparam int SQ_DIV_STEPS   = 2 * Q_BITS;
   localparam int VAR_DIV_STEPS  = DIV_BITS;

   // Register indexes
   localparam logic [2:0] CSR_MEAN_LOW   = 3'd0;
   localparam logic [2:0] CSR_MEAN_HIGH  = 3'd1;
   localparam logic [2:0] CSR_SIGMA_LOW  = 3'd2;
   localparam logic [2:0] CSR_SIGMA_HIGH = 3'd3;
   localparam logic [2:0] CSR_TIMEBIN    = 3'd4;

   typedef struct packed {
      logic [11:0] mean_low;
      logic [11:0] mean_high;
      logic [11:0] sigma_low;
      logic [11:0] sigma_high;
      logic [3:0]  timebin_limit;
   } cfg_type;

   // Classified sample between front and back
   typedef struct packed {
      logic                 ok;
      logic [ADDR_BITS-1:0] idx;
      logic [4:0]           assembly;
      logic [10:0]          strip;
      logic [2:0]           disk;
      logic [11:0]          sample;
      logic [3:0]           time_bin;
   } entry_type;

   // One strip record in the store
   typedef struct packed {
      logic [COUNT_BITS-1:0] osc;
      logic [SSD_BITS-1:0]   ssd;
      logic [Q_BITS-1:0]     mean;
      logic [COUNT_BITS-1:0] count;
   } rec_type;

   typedef enum logic [3:0] {
      B_CLEAR, B_IDLE, B_READ, B_DMEAN, B_DSQ, B_SSD, B_DVAR, B_SQRT, B_DONE
   } back_state_type;

   localparam logic [2:0] DISK_TABLE [24] = '{
      3'd3, 3'd6, 3'd2, 3'd5, 3'd1, 3'd3, 3'd4, 3'd6, 3'd3, 3'd6, 3'd5, 3'd5,
      3'd2, 3'd1, 3'd3, 3'd1, 3'd4, 3'd2, 3'd5, 3'd6, 3'd4, 3'd4, 3'd2, 3'd1};

   function automatic logic [2:0] disk_of(input logic [4:0] asm_id);
      logic [2:0] d;
      d = 3'd0;
      if (asm_id < 5'd24) d = DISK_TABLE[asm_id];
      return d;
   endfunction

endpackage

// ===== sv/pnt_if.sv =====
interface pnt_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  readout_board;
   logic [2:0]  arm_index;
   logic [4:0]  chip_index;
   logic [7:0]  strip_in_chip;
   logic [3:0]  time_bin;
   logic [11:0] sample_value;

   modport source(output valid, readout_board, arm_index, chip_index, strip_in_chip,
                  time_bin, sample_value, input ready);
   modport sink(input valid, readout_board, arm_index, chip_index, strip_in_chip,
                time_bin, sample_value, output ready);
endinterface

interface pnt_rsp_if;
   logic        valid;
   logic        ready;
   logic        accepted;
   logic [4:0]  assembly;
   logic [10:0] strip;
   logic [2:0]  disk;
   logic [19:0] running_mean;
   logic [19:0] running_sigma;
   logic        strip_bad;
   logic        above_sigma;
   logic [11:0] sample_out;
   logic [3:0]  time_bin_out;

   modport source(output valid, accepted, assembly, strip, disk, running_mean,
                  running_sigma, strip_bad, above_sigma, sample_out, time_bin_out,
                  input ready);
   modport sink(input valid, accepted, assembly, strip, disk, running_mean,
                running_sigma, strip_bad, above_sigma, sample_out, time_bin_out,
                output ready);
endinterface

// ===== sv/pnt_front.sv =====
module pnt_front import pnt_pkg::*; (
   input  logic [1:0]  readout_board,
   input  logic [2:0]  arm_index,
   input  logic [4:0]  chip_index,
   input  logic [7:0]  strip_in_chip,
   input  logic [3:0]  time_bin,
   input  logic [11:0] sample_value,
   input  logic [3:0]  timebin_limit,
   output entry_type   entry
);

   logic       addr_ok;
   logic       range_ok;
   logic [5:0] asm_w;
   logic [4:0] chip_sub;
   logic [3:0] chip_m;
   logic [10:0] strip_w;

   // Address checks
   always_comb begin
      addr_ok = (chip_index <= 5'd21) && (chip_index != 5'd10) && (chip_index != 5'd11)
             && ((readout_board == 2'd1) || (readout_board == 2'd2))
             && (arm_index <= 3'd5) && !strip_in_chip[7]
             && (time_bin <= timebin_limit);
   end

   // Assembly and strip mapping
   always_comb begin
      asm_w = ((readout_board == 2'd2) ? 6'd12 : 6'd0) + {2'b00, arm_index, 1'b0}
            + {5'd0, (chip_index > 5'd10)};
      chip_sub = chip_index - 5'd12;
      chip_m   = (chip_index >= 5'd12) ? chip_sub[3:0] : chip_index[3:0];
      strip_w  = {chip_m, strip_in_chip[6:0]};
      range_ok = (32'(asm_w) < ASSEMBLIES) && (32'(strip_w) < STRIPS_PER_ASSEMBLY);
   end

   always_comb begin
      entry.ok       = addr_ok && range_ok;
      entry.idx      = ADDR_BITS'(32'(asm_w) * STRIPS_PER_ASSEMBLY + 32'(strip_w));
      entry.assembly = asm_w[4:0];
      entry.strip    = strip_w;
      entry.disk     = disk_of(asm_w[4:0]);
      entry.sample   = sample_value;
      entry.time_bin = time_bin;
   end

endmodule

// ===== sv/pnt_queue.sv =====
module pnt_queue import pnt_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  entry_type push_entry,
   input  logic      pop,
   output logic      full,
   output logic      nonempty,
   output entry_type head
);

   entry_type  slot_ff [2];
   logic       wp_ff, wp_in;
   logic       rp_ff, rp_in;
   logic [1:0] cnt_ff, cnt_in;

   // Pointers and fill count
   always_comb begin
      wp_in  = push ? ~wp_ff : wp_ff;
      rp_in  = pop ? ~rp_ff : rp_ff;
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) slot_ff[wp_ff] <= push_entry;
   end

   assign full     = cnt_ff[1];
   assign nonempty = (cnt_ff != 2'd0);
   assign head     = slot_ff[rp_ff];

endmodule

// ===== sv/pnt_div.sv =====
module pnt_div import pnt_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [DIV_BITS-1:0]   dividend,
   input  logic [STEP_BITS-1:0]  steps,
   input  logic [COUNT_BITS-1:0] divisor,
   output logic                  done,
   output logic [DIV_BITS-1:0]   quotient
);

   logic                  busy_ff;
   logic                  done_ff;
   logic [STEP_BITS-1:0]  left_ff, left_in;
   logic [DIV_BITS-1:0]   dq_ff, dq_in;
   logic [COUNT_BITS-1:0] rem_ff, rem_in;
   logic [COUNT_BITS-1:0] dvs_ff;

   // Two restoring steps per cycle; dividend arrives left-aligned
   always_comb begin
      logic [COUNT_BITS:0] trial;
      trial  = '0;
      dq_in  = dq_ff;
      rem_in = rem_ff;
      for (int k = 0; k < 2; k++) begin
         if (STEP_BITS'(k) < left_ff) begin
            trial = {rem_in, dq_in[DIV_BITS-1]};
            dq_in = {dq_in[DIV_BITS-2:0], 1'b0};
            if (trial >= {1'b0, dvs_ff}) begin
               trial    = trial - {1'b0, dvs_ff};
               dq_in[0] = 1'b1;
            end
            rem_in = trial[COUNT_BITS-1:0];
         end
      end
      left_in = (left_ff > STEP_BITS'(1)) ? left_ff - STEP_BITS'(2) : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         left_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            left_ff <= steps;
         end else if (busy_ff) begin
            left_ff <= left_in;
            if (left_in == '0) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         dq_ff  <= dividend;
         rem_ff <= '0;
         dvs_ff <= divisor;
      end else if (busy_ff) begin
         dq_ff  <= dq_in;
         rem_ff <= rem_in;
      end
   end

   assign done     = done_ff;
   assign quotient = dq_ff;

endmodule

// ===== sv/pnt_sqrt.sv =====
module pnt_sqrt import pnt_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [DIV_BITS-1:0] operand,
   output logic                done,
   output logic [DIV_BITS/2-1:0] root
);

   localparam int ROOT_BITS = DIV_BITS / 2;
   localparam int REM_BITS  = ROOT_BITS + 4;
   localparam int CYC_BITS  = $clog2(ROOT_BITS / 2 + 1);

   logic                 busy_ff;
   logic                 done_ff;
   logic [CYC_BITS-1:0]  left_ff;
   logic [DIV_BITS-1:0]  v_ff, v_in;
   logic [REM_BITS-1:0]  rem_ff, rem_in;
   logic [ROOT_BITS-1:0] root_ff, root_in;

   // Two result bits per cycle, digit by digit
   always_comb begin
      logic [REM_BITS-1:0] trial;
      v_in    = v_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      trial   = '0;
      for (int k = 0; k < 2; k++) begin
         rem_in = {rem_in[REM_BITS-3:0], v_in[DIV_BITS-1 -: 2]};
         v_in   = {v_in[DIV_BITS-3:0], 2'b00};
         trial  = {2'b00, root_in, 2'b01};
         if (rem_in >= trial) begin
            rem_in  = rem_in - trial;
            root_in = {root_in[ROOT_BITS-2:0], 1'b1};
         end else begin
            root_in = {root_in[ROOT_BITS-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         left_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            left_ff <= CYC_BITS'(ROOT_BITS / 2);
         end else if (busy_ff) begin
            left_ff <= left_ff - CYC_BITS'(1);
            if (left_ff == CYC_BITS'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         v_ff    <= operand;
         rem_ff  <= '0;
         root_ff <= '0;
      end else if (busy_ff) begin
         v_ff    <= v_in;
         rem_ff  <= rem_in;
         root_ff <= root_in;
      end
   end

   assign done = done_ff;
   assign root = root_ff;

endmodule

// ===== sv/pnt_back.sv =====
module pnt_back import pnt_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  cfg_type   cfg,
   input  logic      q_valid,
   input  entry_type q_head,
   output logic      q_pop,
   pnt_rsp_if.source rsp_chan
);

   back_state_type state_ff, state_in;

   // Strip store, one record per strip
   rec_type              mem [STORE_DEPTH];
   rec_type              rd_ff;
   rec_type              wr_rec;
   logic                 mem_we;
   logic [ADDR_BITS-1:0] mem_waddr;
   logic [ADDR_BITS-1:0] clr_ff;

   // Working registers of the current beat
   logic                  full_ff;
   logic [COUNT_BITS-1:0] n_ff;
   logic [Q_BITS-1:0]     mag_ff;
   logic                  neg_ff;
   logic [Q_BITS-1:0]     mean_ff;
   logic [SSD_BITS-1:0]   ssd_ff;
   logic [2*Q_BITS-1:0]   sq_ff;
   logic [Q_BITS-1:0]     sigma_ff;
   logic [COUNT_BITS-1:0] osc_ff;

   // Result register
   logic        rsp_valid_ff;
   logic        acc_ff;
   logic [4:0]  asm_ff;
   logic [10:0] strip_ff;
   logic [2:0]  disk_ff;
   logic [19:0] rmean_ff;
   logic [19:0] rsigma_ff;
   logic        bad_ff;
   logic        above_ff;
   logic [11:0] sout_ff;
   logic [3:0]  tbout_ff;

   // Shared units
   logic                  div_start;
   logic [DIV_BITS-1:0]   div_dividend;
   logic [STEP_BITS-1:0]  div_steps;
   logic [COUNT_BITS-1:0] div_divisor;
   logic                  div_done;
   logic [DIV_BITS-1:0]   div_q;
   logic                  sqrt_start;
   logic                  sqrt_done;
   logic [DIV_BITS/2-1:0] sqrt_root;

   // Datapath helpers
   logic                      out_free;
   logic                      rd_full;
   logic [COUNT_BITS-1:0]     n_next;
   logic [Q_BITS-1:0]         x_q;
   logic [Q_BITS:0]           d_w;
   logic [Q_BITS:0]           d_abs;
   logic [MEAN_DIV_STEPS-1:0] mean_num;
   logic [2*Q_BITS-1:0]       sq_diff;
   logic [2*Q_BITS:0]         inc_w;
   logic [SSD_BITS:0]         ssd_sum;
   logic [Q_BITS+1:0]         dnew;
   logic                      above;
   logic                      bad;

   pnt_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .steps    (div_steps),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_q)
   );

   pnt_sqrt u_sqrt (
      .clock   (clock),
      .reset   (reset),
      .start   (sqrt_start),
      .operand (div_q),
      .done    (sqrt_done),
      .root    (sqrt_root)
   );

   // Datapath terms
   always_comb begin
      out_free = !rsp_valid_ff || rsp_chan.ready;
      rd_full  = (rd_ff.count == COUNT_MAX);
      n_next   = rd_ff.count + COUNT_BITS'(1);
      x_q      = {q_head.sample, 8'h00};
      d_w      = {1'b0, x_q} - {1'b0, rd_ff.mean};
      d_abs    = d_w[Q_BITS] ? (~d_w + (Q_BITS+1)'(1)) : d_w;
      mean_num = MEAN_DIV_STEPS'(d_abs[Q_BITS-1:0]) + MEAN_DIV_STEPS'(n_next >> 1);
      sq_diff  = sq_ff - div_q[2*Q_BITS-1:0];
      inc_w    = ({1'b0, sq_diff} + (2*Q_BITS+1)'(128)) >> 8;
      ssd_sum  = {1'b0, ssd_ff} + (SSD_BITS+1)'(inc_w);
      dnew     = {2'b00, x_q} - {2'b00, mean_ff};
      above    = (sigma_ff != '0) && ($signed(dnew) > $signed({2'b00, sigma_ff}));
      bad      = (mean_ff < {cfg.mean_low, 8'h00}) || (mean_ff > {cfg.mean_high, 8'h00})
              || (sigma_ff < {cfg.sigma_low, 8'h00})
              || (sigma_ff > {cfg.sigma_high, 8'h00});
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         B_CLEAR: if (clr_ff == ADDR_BITS'(STORE_DEPTH - 1)) state_in = B_IDLE;
         B_IDLE:  if (q_valid) state_in = q_head.ok ? B_READ : B_DONE;
         B_READ:  state_in = rd_full ? B_DVAR : B_DMEAN;
         B_DMEAN: if (div_done) state_in = B_DSQ;
         B_DSQ:   if (div_done) state_in = B_SSD;
         B_SSD:   state_in = B_DVAR;
         B_DVAR:  if (div_done) state_in = B_SQRT;
         B_SQRT:  if (sqrt_done) state_in = B_DONE;
         B_DONE:  if (out_free) state_in = B_IDLE;
         default: state_in = B_IDLE;
      endcase
   end

   // Unit starts, store write, queue pop
   always_comb begin
      div_start    = 1'b0;
      div_dividend = {ssd_ff, 8'h00};
      div_steps    = STEP_BITS'(VAR_DIV_STEPS);
      div_divisor  = n_ff;
      sqrt_start   = 1'b0;
      mem_we       = 1'b0;
      q_pop        = 1'b0;
      unique case (state_ff)
         B_READ: begin
            div_start = 1'b1;
            if (rd_full) begin
               div_dividend = {rd_ff.ssd, 8'h00};
               div_divisor  = rd_ff.count;
            end else begin
               div_dividend = {mean_num, (DIV_BITS - MEAN_DIV_STEPS)'(0)};
               div_steps    = STEP_BITS'(MEAN_DIV_STEPS);
               div_divisor  = n_next;
            end
         end
         B_DMEAN: begin
            div_start    = div_done;
            div_dividend = {sq_ff, (DIV_BITS - SQ_DIV_STEPS)'(0)};
            div_steps    = STEP_BITS'(SQ_DIV_STEPS);
         end
         B_SSD:   div_start = 1'b1;
         B_DVAR:  sqrt_start = div_done;
         B_CLEAR: mem_we = 1'b1;
         B_DONE: begin
            q_pop  = out_free;
            mem_we = out_free && q_head.ok && !full_ff;
         end
         default: ;
      endcase
   end

   always_comb begin
      mem_waddr = (state_ff == B_CLEAR) ? clr_ff : q_head.idx;
      if (state_ff == B_CLEAR) begin
         wr_rec = '0;
      end else begin
         wr_rec.count = n_ff;
         wr_rec.mean  = mean_ff;
         wr_rec.ssd   = ssd_ff;
         wr_rec.osc   = osc_ff + COUNT_BITS'(above && (osc_ff != COUNT_MAX));
      end
   end

   // Store: one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_waddr] <= wr_rec;
      rd_ff <= mem[q_head.idx];
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == B_CLEAR) clr_ff <= clr_ff + ADDR_BITS'(1);
         if (q_pop) rsp_valid_ff <= 1'b1;
         else if (rsp_chan.ready) rsp_valid_ff <= 1'b0;
      end
   end

   // Working registers
   always_ff @(posedge clock) begin
      sq_ff <= mag_ff * mag_ff;
      unique case (state_ff)
         B_READ: begin
            full_ff <= rd_full;
            n_ff    <= rd_full ? rd_ff.count : n_next;
            mag_ff  <= d_abs[Q_BITS-1:0];
            neg_ff  <= d_w[Q_BITS];
            mean_ff <= rd_ff.mean;
            ssd_ff  <= rd_ff.ssd;
            osc_ff  <= rd_ff.osc;
         end
         B_DMEAN: if (div_done) begin
            mean_ff <= neg_ff ? mean_ff - div_q[Q_BITS-1:0] : mean_ff + div_q[Q_BITS-1:0];
         end
         B_DSQ: if (div_done) begin
            ssd_ff <= ssd_sum[SSD_BITS] ? '1 : ssd_sum[SSD_BITS-1:0];
         end
         B_SQRT: if (sqrt_done) begin
            sigma_ff <= (|sqrt_root[DIV_BITS/2-1:Q_BITS]) ? '1 : sqrt_root[Q_BITS-1:0];
         end
         default: ;
      endcase
   end

   // Result register
   always_ff @(posedge clock) begin
      if (q_pop) begin
         acc_ff    <= q_head.ok;
         asm_ff    <= q_head.ok ? q_head.assembly : 5'd0;
         strip_ff  <= q_head.ok ? q_head.strip : 11'd0;
         disk_ff   <= q_head.ok ? q_head.disk : 3'd0;
         rmean_ff  <= q_head.ok ? mean_ff : 20'd0;
         rsigma_ff <= q_head.ok ? sigma_ff : 20'd0;
         bad_ff    <= q_head.ok && bad;
         above_ff  <= q_head.ok && above;
         sout_ff   <= q_head.sample;
         tbout_ff  <= q_head.time_bin;
      end
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.accepted      = acc_ff;
   assign rsp_chan.assembly      = asm_ff;
   assign rsp_chan.strip         = strip_ff;
   assign rsp_chan.disk          = disk_ff;
   assign rsp_chan.running_mean  = rmean_ff;
   assign rsp_chan.running_sigma = rsigma_ff;
   assign rsp_chan.strip_bad     = bad_ff;
   assign rsp_chan.above_sigma   = above_ff;
   assign rsp_chan.sample_out    = sout_ff;
   assign rsp_chan.time_bin_out  = tbout_ff;

   // Store writes only during the clearing pass or at the end of a beat
   a_write_state: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> (state_ff == B_CLEAR || state_ff == B_DONE))
      else $error("store written outside clear or done");

   // A pop never runs ahead of the queue
   a_pop_valid: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_valid)
      else $error("pop from empty queue");

   // Every finished beat shows up on the result side
   a_result_shown: assert property (@(posedge clock) disable iff (reset)
      q_pop |=> rsp_chan.valid)
      else $error("finished beat not presented");

endmodule

// ===== sv/channel_pedestal_noise_tracker.sv =====
// Channel   Dir  Handshake          Payload
// req_chan  in   valid/ready        board, arm, chip, strip in chip, timebin, sample
// rsp_chan  out  valid/ready        accepted, assembly, strip, disk, mean, sigma, flags, sample, timebin
// csr_*     in   csr_we, no ready   register index and 12-bit data
//
// A valid sample runs a mean divide, a squared-deviation divide and a variance
// divide, all on one two-bit-per-cycle divider, then a square root. A sample on a
// saturated strip skips the first two divides; a dropped one skips all arithmetic.
// Reset is synchronous; after it the strip store is cleared one entry per cycle,
// and no queued sample is processed until that pass ends.
// A two-beat queue parts intake from the update engine; results wait in a register.
module channel_pedestal_noise_tracker import pnt_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   pnt_req_if.sink     req_chan,
   pnt_rsp_if.source   rsp_chan,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [11:0] csr_wdata
);

   cfg_type   cfg_ff;
   entry_type front_entry;
   entry_type q_head;
   logic      q_full;
   logic      q_nonempty;
   logic      q_pop;
   logic      push;

   // Limit registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.mean_low      <= 12'd250;
         cfg_ff.mean_high     <= 12'd1500;
         cfg_ff.sigma_low     <= 12'd5;
         cfg_ff.sigma_high    <= 12'd250;
         cfg_ff.timebin_limit <= 4'd7;
      end else if (csr_we) begin
         case (csr_index)
            CSR_MEAN_LOW:   cfg_ff.mean_low      <= csr_wdata;
            CSR_MEAN_HIGH:  cfg_ff.mean_high     <= csr_wdata;
            CSR_SIGMA_LOW:  cfg_ff.sigma_low     <= csr_wdata;
            CSR_SIGMA_HIGH: cfg_ff.sigma_high    <= csr_wdata;
            CSR_TIMEBIN:    cfg_ff.timebin_limit <= csr_wdata[3:0];
            default: ;
         endcase
      end
   end

   pnt_front u_front (
      .readout_board (req_chan.readout_board),
      .arm_index     (req_chan.arm_index),
      .chip_index    (req_chan.chip_index),
      .strip_in_chip (req_chan.strip_in_chip),
      .time_bin      (req_chan.time_bin),
      .sample_value  (req_chan.sample_value),
      .timebin_limit (cfg_ff.timebin_limit),
      .entry         (front_entry)
   );

   assign req_chan.ready = !q_full;
   assign push           = req_chan.valid && !q_full;

   pnt_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (front_entry),
      .pop        (q_pop),
      .full       (q_full),
      .nonempty   (q_nonempty),
      .head       (q_head)
   );

   pnt_back u_back (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .q_valid  (q_nonempty),
      .q_head   (q_head),
      .q_pop    (q_pop),
      .rsp_chan (rsp_chan)
   );

endmodule
